[rtl/swm_pkg.sv]
package swm_pkg;

	// Width of the window_size register as written on the configuration port.
	localparam int CFG_BITS = 7;

	// Controls broadcast from the top level to every cell of the chain.
	typedef struct packed {
		logic step;  // a sample is taken this cycle
		logic full;  // the window holds window_size samples, so one leaves
	} swm_ctl_t;

endpackage

[rtl/swm_cell.sv]
// One slot of the sorted chain. It holds one sample and its age in samples.
// On a step each cell picks its next content from itself, its two neighbors
// or the new sample, so that the chain stays sorted while the oldest sample
// drops out and the new one slides in.
module swm_cell #(
	parameter int W  = 32,
	parameter int AW = 6
) (
	input  logic                 clk,
	input  swm_pkg::swm_ctl_t    ctl,
	input  logic signed [W-1:0]  x,          // new sample
	input  logic [AW-1:0]        last_age,   // age of the sample that leaves
	input  logic                 valid,      // this slot holds a sample
	input  logic                 ge_prev,    // the leaving slot is at or below the lower neighbor
	input  logic                 ge_here,    // the leaving slot is at or below this slot
	input  logic signed [W-1:0]  prev_value,
	input  logic [AW-1:0]        prev_age,
	input  logic                 prev_gt,
	input  logic signed [W-1:0]  next_value,
	input  logic [AW-1:0]        next_age,
	input  logic                 next_gt,
	output logic signed [W-1:0]  value,
	output logic [AW-1:0]        age,
	output logic                 gt,
	output logic                 rm
);

	logic signed [W-1:0] value_q;
	logic [AW-1:0]       age_q;
	logic                gtc_here;
	logic                gtc_prev;
	logic signed [W-1:0] c_value;
	logic [AW-1:0]       c_age;
	logic signed [W-1:0] p_value;
	logic [AW-1:0]       p_age;

	// An empty slot counts as greater than any sample.
	assign gt    = !valid | (value_q > x);
	assign rm    = ctl.full & valid & (age_q == last_age);
	assign value = value_q;
	assign age   = age_q;

	// View of this slot and the lower one after the leaving sample is taken out.
	always_comb begin
		gtc_here = ge_here ? next_gt    : gt;
		c_value  = ge_here ? next_value : value_q;
		c_age    = ge_here ? next_age   : age_q;
		gtc_prev = ge_prev ? gt         : prev_gt;
		p_value  = ge_prev ? value_q    : prev_value;
		p_age    = ge_prev ? age_q      : prev_age;
	end

	// Keep, shift down from above, take the new sample, or shift up from below.
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (!gtc_here) begin
				value_q <= c_value;
				age_q   <= c_age + AW'(1);
			end else if (!gtc_prev) begin
				value_q <= x;
				age_q   <= '0;
			end else begin
				value_q <= p_value;
				age_q   <= p_age + AW'(1);
			end
		end
	end

endmodule

[rtl/sliding_window_median.sv]
// Channel   | Direction | Signals                      | Word
// s_        | in        | s_tvalid s_tready s_tdata    | sample
// m_        | out       | m_tvalid m_tready m_tdata    | median
// cfg_      | in        | cfg_we cfg_wdata             | window_size
//
// One sample is taken per cycle while s_tready is high; every slot of the
// sorted cell chain updates in that same cycle. The median is read from the
// updated chain into the output register once that register is free. Reset
// empties the window and sets window_size to 1. A full output register with
// m_tready low stalls the input only once a second result is waiting.
// A write of window_size empties the window; filling starts over.
module sliding_window_median #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] median
	input  logic                                cfg_we,
	input  logic [swm_pkg::CFG_BITS-1:0]        cfg_wdata
);

	localparam int N  = WINDOW_MAX;
	localparam int W  = SAMPLE_BITS;
	localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int VW = (CW > swm_pkg::CFG_BITS) ? CW : swm_pkg::CFG_BITS;

	logic [CW-1:0]       k_q;
	logic [AW-1:0]       last_age_q;
	logic [AW-1:0]       mid_q;
	logic [CW-1:0]       fill_q;
	logic                emit_s1;
	logic                m_valid_q;
	logic signed [W-1:0] m_data_q;

	logic [VW-1:0]       cfg_v;
	logic [VW-1:0]       cfg_k;
	logic [VW-1:0]       cfg_km1;
	logic [CW-1:0]       fill_inc;
	logic                full;
	logic                step;
	logic                emit_next;
	logic                out_free;
	logic signed [W-1:0] x;
	swm_pkg::swm_ctl_t   ctl;

	logic signed [W-1:0] val [N];
	logic [AW-1:0]       age [N];
	logic [N-1:0]        gt;
	logic [N-1:0]        rm;
	logic [N-1:0]        ge;

	// Saturate the written window size into the range the chain supports.
	always_comb begin
		cfg_v   = VW'(cfg_wdata);
		cfg_k   = (cfg_v == '0) ? VW'(1)
		        : (cfg_v > VW'(WINDOW_MAX)) ? VW'(WINDOW_MAX) : cfg_v;
		cfg_km1 = cfg_k - VW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= CW'(1);
			last_age_q <= '0;
			mid_q      <= '0;
		end else if (cfg_we) begin
			k_q        <= cfg_k[CW-1:0];
			last_age_q <= cfg_km1[AW-1:0];
			mid_q      <= AW'(cfg_km1 >> 1);
		end
	end

	// Fill control: a result is due once the window is full after this sample.
	assign x         = s_tdata[W-1:0];
	assign full      = (fill_q == k_q);
	assign fill_inc  = fill_q + CW'(1);
	assign emit_next = full | (fill_inc == k_q);
	assign out_free  = !m_valid_q | m_tready;
	assign s_tready  = !emit_s1 | out_free;
	assign step      = s_tvalid & s_tready;
	assign ctl.step  = step;
	assign ctl.full  = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg_we) begin
			fill_q <= '0;
		end else if (step && !full) begin
			fill_q <= fill_inc;
		end
	end

	// The leaving slot lies at or below slot i.
	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_ge
			localparam logic [N-1:0] MASK = {N{1'b1}} >> (N - 1 - i);
			assign ge[i] = |(rm & MASK);
		end
	endgenerate

	// The sorted chain: each cell talks to its neighbors; an end cell has only one.
	generate
		for (i = 0; i < N; i++) begin : g_cell
			logic signed [W-1:0] pv;
			logic [AW-1:0]       pa;
			logic                pg;
			logic                gp;
			logic signed [W-1:0] nv;
			logic [AW-1:0]       na;
			logic                ng;

			if (i == 0) begin : g_lo
				assign pv = val[i];
				assign pa = age[i];
				assign pg = 1'b0;
				assign gp = 1'b0;
			end else begin : g_lo
				assign pv = val[i-1];
				assign pa = age[i-1];
				assign pg = gt[i-1];
				assign gp = ge[i-1];
			end

			if (i == N - 1) begin : g_hi
				assign nv = val[i];
				assign na = age[i];
				assign ng = 1'b1;
			end else begin : g_hi
				assign nv = val[i+1];
				assign na = age[i+1];
				assign ng = gt[i+1];
			end

			swm_cell #(
				.W  (W),
				.AW (AW)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.x          (x),
				.last_age   (last_age_q),
				.valid      (CW'(i) < fill_q),
				.ge_prev    (gp),
				.ge_here    (ge[i]),
				.prev_value (pv),
				.prev_age   (pa),
				.prev_gt    (pg),
				.next_value (nv),
				.next_age   (na),
				.next_gt    (ng),
				.value      (val[i]),
				.age        (age[i]),
				.gt         (gt[i]),
				.rm         (rm[i])
			);
		end
	endgenerate

	// Result pending flag and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				m_valid_q <= emit_s1;
			end
			if (!emit_s1 || out_free) begin
				emit_s1 <= step & emit_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_s1 && out_free) begin
			m_data_q <= val[mid_q];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = DW'($unsigned(m_data_q));

endmodule

[rtl/swm_checker.sv]
// Port-level checks for the median filter.
module swm_checker #(
	parameter int DW = 32
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [DW-1:0] m_tdata
);

	// A result waiting on the output holds its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("median word changed while stalled");

	// No result is shown while reset is applied.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result shown during reset");

	// Input stalls only behind a blocked output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// A fresh result comes from an accepted sample.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching sample");

endmodule

bind sliding_window_median swm_checker #(
	.DW ($bits(m_tdata))
) u_swm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/sv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CFG_BITS    = swm_pkg::CFG_BITS;
	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 32;
	// This limit leaves a wide margin over the slowest correct run.
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 4;

	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

	typedef struct {
		row_kind_t   kind;
		logic [31:0] value;
		bit          given;
		logic [31:0] want;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [31:0]         s_tdata;   // [31:0] sample
	logic                m_tvalid;
	logic                m_tready;
	logic [31:0]         m_tdata;   // [31:0] median
	logic                cfg_we;
	logic [CFG_BITS-1:0] cfg_wdata;

	// A directed word can carry its own expected median, which travels beside the data.
	bit          exp_given;
	logic [31:0] exp_value;
	bit          hold_request;

	// This is the predictor state: the window in arrival order and in sorted order.
	logic signed [31:0] ring_words[WINDOW_MAX];
	logic signed [31:0] sorted_words[WINDOW_MAX];
	int unsigned        fill_cnt = 0;
	int unsigned        oldest_idx = 0;
	logic [CFG_BITS-1:0] win_reg = CFG_BITS'(1);

	logic [31:0] medians_due[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	row_t        directed_rows[$];

	sliding_window_median #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Put a sample into the sorted store, which holds cnt entries.
	function automatic void sorted_put(input logic signed [31:0] v, input int unsigned cnt);
		int unsigned i;
		i = cnt;
		while (i > 0 && sorted_words[i-1] > v) begin
			sorted_words[i] = sorted_words[i-1];
			i--;
		end
		sorted_words[i] = v;
	endfunction

	// Take one entry equal to v out of the sorted store, which holds cnt entries.
	function automatic void sorted_drop(input logic signed [31:0] v, input int unsigned cnt);
		int unsigned i;
		i = 0;
		while (i < cnt && sorted_words[i] != v)
			i++;
		for (; i + 1 < cnt; i++)
			sorted_words[i] = sorted_words[i+1];
	endfunction

	// Slide one sample into the window.
	// This returns 1 and the lower median once the window is full.
	function automatic bit advance_window(input logic signed [31:0] s,
			output logic signed [31:0] med);
		int unsigned k;
		int unsigned p;
		logic signed [31:0] leaving;
		k = (win_reg == 0) ? 1 : ((win_reg > WINDOW_MAX) ? WINDOW_MAX : win_reg);
		med = '0;
		if (fill_cnt < k) begin
			ring_words[fill_cnt] = s;
			sorted_put(s, fill_cnt);
			fill_cnt++;
			if (fill_cnt < k)
				return 1'b0;
		end else begin
			p = oldest_idx % k;
			leaving = ring_words[p];
			ring_words[p] = s;
			oldest_idx = (p + 1) % k;
			sorted_drop(leaving, k);
			sorted_put(s, k - 1);
		end
		med = sorted_words[(k-1)/2];
		return 1'b1;
	endfunction

	// Append a median to the list of results still due.
	function automatic void queue_median(input logic [31:0] v);
		medians_due = {medians_due, v};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < 30)
			$display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Track config writes and accepted samples, and check every accepted median.
	always @(posedge clk) begin
		logic signed [31:0] med;
		logic [31:0] want;
		if (cfg_we) begin
			win_reg = cfg_wdata;
			fill_cnt = 0;
			oldest_idx = 0;
		end
		if (s_tvalid && s_tready) begin
			if (advance_window(s_tdata, med))
				queue_median(exp_given ? exp_value : med);
		end
		if (m_tvalid && m_tready) begin
			if (medians_due.size() == 0) begin
				report_mismatch("unexpected median", m_tdata, 'x);
			end else begin
				want = medians_due.pop_front();
				if (m_tdata !== want)
					report_mismatch("median", m_tdata, want);
			end
		end
	end

	// This is the watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The receiver stalls in patterns that change now and then.
	// Once on request, it holds off for a long stretch.
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		bit       hold_done;
		m_tready <= 1'b0;
		mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					RX_OPEN: begin
						m_tready <= 1'b1;
					end
					RX_COIN: begin
						m_tready <= 1'($urandom_range(0, 1));
					end
					RX_SPARSE: begin
						m_tready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						m_tready <= mode_left[2];
					end
				endcase
			end
		end
	end

	// Offer one word. Before it, a random gap may come when a burst has run out.
	task automatic put_word(input logic [31:0] v, input bit given, input logic [31:0] want);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(60, 150);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 6);
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= v;
		exp_given <= given;
		exp_value <= want;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Let the block go idle, then write window_size.
	task automatic write_window(input logic [CFG_BITS-1:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (medians_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// The random samples mix full-range values, small values that repeat often, and the extremes.
	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 9)) inside
			[0:3]: return $urandom;
			[4:6]: return $urandom_range(0, 16) - 8;
			7: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return ($urandom_range(0, 3) << 30) | $urandom_range(0, 7);
		endcase
	endfunction

	function automatic row_t row(input row_kind_t kind, input logic [31:0] value,
			input bit given, input logic [31:0] want);
		row_t r;
		r.kind = kind;
		r.value = value;
		r.given = given;
		r.want = want;
		return r;
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(input row_kind_t kind, input logic [31:0] value,
			input bit given, input logic [31:0] want);
		directed_rows = {directed_rows, row(kind, value, given, want)};
	endfunction

	// Stimulus: the directed table first, then random phases at many window sizes.
	initial begin
		int unsigned size_plan[$];
		int unsigned k;
		int          n;
		row_t        r;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		exp_given <= 1'b0;
		exp_value <= '0;
		hold_request <= 1'b0;

		// After reset the window holds one sample, so every median is the sample itself.
		add_row(ROW_WORD, 32'h8000_0000, 1'b1, 32'h8000_0000);
		add_row(ROW_WORD, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff);
		add_row(ROW_WORD, 32'h0000_0000, 1'b1, 32'h0000_0000);
		add_row(ROW_WORD, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
		add_row(ROW_WORD, 32'h5555_5555, 1'b1, 32'h5555_5555);
		add_row(ROW_WORD, 32'haaaa_aaaa, 1'b1, 32'haaaa_aaaa);
		// A window size of zero acts as one.
		add_row(ROW_CFG, 32'd0, 1'b0, '0);
		add_row(ROW_WORD, 32'h0000_007b, 1'b1, 32'h0000_007b);
		add_row(ROW_WORD, 32'hffff_fffb, 1'b1, 32'hffff_fffb);
		// Use a window of three with equal samples leaving and entering.
		add_row(ROW_CFG, 32'd3, 1'b0, '0);
		add_row(ROW_WORD, 32'h0000_0005, 1'b0, '0);
		add_row(ROW_WORD, 32'hffff_fff9, 1'b0, '0);
		add_row(ROW_WORD, 32'h0000_0005, 1'b0, '0);
		add_row(ROW_WORD, 32'h0000_0005, 1'b0, '0);
		add_row(ROW_WORD, 32'h0000_0009, 1'b0, '0);
		add_row(ROW_WORD, 32'hffff_fff9, 1'b0, '0);
		add_row(ROW_WORD, 32'h8000_0000, 1'b0, '0);
		// With a window of two, the lower median is the smaller sample.
		add_row(ROW_CFG, 32'd2, 1'b0, '0);
		add_row(ROW_WORD, 32'h7fff_ffff, 1'b0, '0);
		add_row(ROW_WORD, 32'h8000_0000, 1'b1, 32'h8000_0000);
		add_row(ROW_WORD, 32'h7fff_ffff, 1'b1, 32'h8000_0000);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.kind == ROW_CFG)
				write_window(r.value[CFG_BITS-1:0]);
			else
				put_word(r.value, r.given, r.want);
		end

		// The plan covers the full window, sizes that saturate, zero, one,
		// and several random sizes.
		size_plan = '{64, 2, 127, 1, 5, 0, 16, 65, 3};
		repeat (3) size_plan = {size_plan, $urandom_range(0, 127)};
		foreach (size_plan[ph]) begin
			write_window(CFG_BITS'(size_plan[ph]));
			k = (size_plan[ph] == 0) ? 1 : ((size_plan[ph] > WINDOW_MAX) ? WINDOW_MAX :
				size_plan[ph]);
			n = k + $urandom_range(40, 100);
			if (ph == 1)
				hold_request <= 1'b1;
			repeat (n) put_word(pick_sample(), 1'b0, '0);
		end

		// Wait for every median that is still due, then let the pipeline settle.
		s_tvalid <= 1'b0;
		while (medians_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
